### rtl/rpd_pkg.sv
// ----------------------------------------------------------------------------
// rpd_pkg
// shared widths, limits and register indexes of the ramped pd speed controller
// ----------------------------------------------------------------------------
package rpd_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int DUTY_W    = 8;
    localparam int RSP_W     = 13;

    localparam int SP_W      = 24;
    localparam int RAMP_W    = 26;
    localparam int DIFF_W    = 25;
    localparam int ERR_W     = 19;
    localparam int DERR_W    = 20;
    localparam int ACC_W     = 16;
    localparam int SUM_W     = 38;
    localparam int DINC_W    = SUM_W - 12;
    localparam int ACCX_W    = DINC_W + 1;

    localparam int MUL_A_W   = DIFF_W;
    localparam int MUL_B_W   = 17;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

    localparam logic signed [RAMP_W-1:0] SP_MAX   = RAMP_W'(8388607);
    localparam logic signed [RAMP_W-1:0] SP_MIN   = -RAMP_W'(8388608);
    localparam logic signed [DINC_W-1:0] ERR_LIM  = DINC_W'(1023 * 256);
    localparam logic signed [ACCX_W-1:0] DUTY_LIM = ACCX_W'(100 * 256);

    localparam logic [15:0] RST_ACCEL = 16'd2560;
    localparam logic [15:0] RST_SCALE = 16'd6242;
    localparam logic [15:0] RST_KP    = 16'd451;
    localparam logic [15:0] RST_KD    = 16'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET  = 3'd0,
        CFG_ACCEL   = 3'd1,
        CFG_FORWARD = 3'd2,
        CFG_STOP    = 3'd3,
        CFG_SCALE   = 3'd4,
        CFG_KP      = 3'd5,
        CFG_KD      = 3'd6
    } t_cfg_idx;

endpackage

### rtl/rpd_in_if.sv
// ----------------------------------------------------------------------------
// rpd_in_if
// input channel: one measured speed word per control tick
// ----------------------------------------------------------------------------
interface rpd_in_if #(
    parameter int SPEED_BITS = 12
);
    logic                         valid;
    logic                         ready;
    logic signed [SPEED_BITS-1:0] measured_speed;

    modport source (output valid, output measured_speed, input ready);
    modport sink   (input valid, input measured_speed, output ready);
endinterface

### rtl/rpd_out_if.sv
// ----------------------------------------------------------------------------
// rpd_out_if
// output channel: duty, ramped setpoint and clamp flag per control tick
// ----------------------------------------------------------------------------
interface rpd_out_if;
    import rpd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DUTY_W-1:0] duty;
    logic signed [RSP_W-1:0]  ramped_setpoint;
    logic                     clamped;

    modport source (output valid, output duty, output ramped_setpoint, output clamped,
                    input ready);
    modport sink   (input valid, input duty, input ramped_setpoint, input clamped,
                    output ready);
endinterface

### rtl/ramped_incremental_pd_motor_speed.sv
// ----------------------------------------------------------------------------
// ramped_incremental_pd_motor_speed
// velocity form pd speed controller with a ramped setpoint
// ----------------------------------------------------------------------------
// One measured speed word is taken per control tick and one result word is
// returned: the new duty in percent, the integer part of the ramped setpoint
// and a flag set when the duty hit its limit. A tick runs one ramp step,
// then three passes through a single shared multiplier for error scaling,
// proportional term and derivative term, saturation and the accumulator
// update; the result is then presented and the input is ready again once
// the sequencer is back in idle. The input is not ready while a tick is in
// progress; a finished result waits in the output register, so the next
// tick can be accepted while it is still untaken, and that next tick holds
// in its last step until the output register is free.
// Configuration writes take effect at once and are meant for idle periods.
// ----------------------------------------------------------------------------
module ramped_incremental_pd_motor_speed #(
    parameter int SPEED_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    rpd_in_if.sink                            i_in,
    rpd_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [rpd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rpd_pkg::CFG_W-1:0]         i_cfg_data
);
    import rpd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_RAMP, S_ERR, S_SAT, S_PROP, S_DERIV, S_ACC, S_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic signed [SPEED_BITS-1:0] r_target;
    logic [15:0]                  r_accel;
    logic                         r_forward;
    logic                         r_stop;
    logic [15:0]                  r_scale;
    logic [15:0]                  r_kp;
    logic [15:0]                  r_kd;

    // controller state
    logic signed [SP_W-1:0]       r_sp;
    logic signed [ACC_W-1:0]      r_acc;
    logic signed [ERR_W-1:0]      r_last;

    // working registers
    logic signed [SPEED_BITS-1:0] r_speed;
    logic signed [ERR_W-1:0]      r_e;
    logic signed [SUM_W-1:0]      r_sum;
    logic                         r_clip;

    // output word
    logic                         r_out_valid;
    logic signed [DUTY_W-1:0]     r_duty;
    logic signed [RSP_W-1:0]      r_rsp;
    logic                         r_clamped;

    logic                         mul_en;
    logic signed [MUL_A_W-1:0]    mul_a;
    logic signed [MUL_B_W-1:0]    mul_b;
    logic signed [MUL_P_W-1:0]    mul_p;

    rpd_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // ramp step
    logic signed [RAMP_W-1:0] sp_x, tgt_x, step_x, ramp_v, n_sp_x;
    logic signed [SP_W-1:0]   n_sp;

    always_comb begin
        sp_x   = RAMP_W'(r_sp);
        tgt_x  = RAMP_W'(r_target) <<< 8;
        step_x = RAMP_W'(r_accel);
        if (!r_stop) begin
            if (r_forward) begin
                ramp_v = (sp_x < tgt_x) ? sp_x + step_x : tgt_x;
            end else begin
                ramp_v = (sp_x > tgt_x) ? sp_x - step_x : tgt_x;
            end
        end else begin
            if (r_forward) begin
                ramp_v = (sp_x > 0) ? sp_x - step_x : '0;
            end else begin
                ramp_v = (sp_x < 0) ? sp_x + step_x : '0;
            end
        end
        priority if (ramp_v > SP_MAX) begin
            n_sp_x = SP_MAX;
        end else if (ramp_v < SP_MIN) begin
            n_sp_x = SP_MIN;
        end else begin
            n_sp_x = ramp_v;
        end
        n_sp = n_sp_x[SP_W-1:0];
    end

    // multiplier operand select
    logic signed [DIFF_W-1:0] diff;
    logic signed [DERR_W-1:0] derr;

    always_comb begin
        diff   = DIFF_W'(r_sp) - (DIFF_W'(r_speed) <<< 8);
        derr   = DERR_W'(r_e) - DERR_W'(r_last);
        mul_en = (r_state == S_ERR) || (r_state == S_PROP) || (r_state == S_DERIV);
        unique case (r_state)
            S_ERR: begin
                mul_a = diff;
                mul_b = signed'({1'b0, r_scale});
            end
            S_PROP: begin
                mul_a = MUL_A_W'(r_e);
                mul_b = signed'({1'b0, r_kp});
            end
            default: begin
                mul_a = MUL_A_W'(derr);
                mul_b = signed'({1'b0, r_kd});
            end
        endcase
    end

    // error saturation
    logic signed [DINC_W-1:0] e_raw;
    logic signed [ERR_W-1:0]  n_e;

    always_comb begin
        e_raw = mul_p[MUL_P_W-1:16];
        priority if (e_raw > ERR_LIM) begin
            n_e = ERR_LIM[ERR_W-1:0];
        end else if (e_raw < -ERR_LIM) begin
            n_e = -ERR_LIM[ERR_W-1:0];
        end else begin
            n_e = e_raw[ERR_W-1:0];
        end
    end

    // accumulator update
    logic signed [SUM_W-1:0]  sum;
    logic signed [ACCX_W-1:0] acc_x;
    logic signed [ACC_W-1:0]  n_acc;
    logic                     n_clip;

    always_comb begin
        sum   = r_sum + mul_p[SUM_W-1:0];
        acc_x = ACCX_W'(r_acc) + ACCX_W'(signed'(sum[SUM_W-1:12]));
        priority if (acc_x > DUTY_LIM) begin
            n_acc  = DUTY_LIM[ACC_W-1:0];
            n_clip = 1'b1;
        end else if (acc_x < -DUTY_LIM) begin
            n_acc  = -DUTY_LIM[ACC_W-1:0];
            n_clip = 1'b1;
        end else begin
            n_acc  = acc_x[ACC_W-1:0];
            n_clip = 1'b0;
        end
    end

    // truncation toward zero of the output fields
    logic signed [ACC_W:0]  acc_s, acc_m, acc_q;
    logic signed [SP_W:0]   sp_s, sp_m, sp_q;
    logic signed [DUTY_W-1:0] n_duty;
    logic signed [RSP_W-1:0]  n_rsp;

    always_comb begin
        acc_s  = (ACC_W+1)'(r_acc);
        acc_m  = acc_s[ACC_W] ? -acc_s : acc_s;
        acc_q  = acc_s[ACC_W] ? -(acc_m >>> 8) : (acc_m >>> 8);
        n_duty = acc_q[DUTY_W-1:0];
        sp_s   = (SP_W+1)'(r_sp);
        sp_m   = sp_s[SP_W] ? -sp_s : sp_s;
        sp_q   = sp_s[SP_W] ? -(sp_m >>> 8) : (sp_m >>> 8);
        n_rsp  = sp_q[RSP_W-1:0];
    end

    logic out_free;
    assign out_free = !r_out_valid || o_out.ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= '0;
            r_accel   <= RST_ACCEL;
            r_forward <= 1'b1;
            r_stop    <= 1'b1;
            r_scale   <= RST_SCALE;
            r_kp      <= RST_KP;
            r_kd      <= RST_KD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TARGET:  r_target  <= i_cfg_data[SPEED_BITS-1:0];
                CFG_ACCEL:   r_accel   <= i_cfg_data[15:0];
                CFG_FORWARD: r_forward <= i_cfg_data[0];
                CFG_STOP:    r_stop    <= i_cfg_data[0];
                CFG_SCALE:   r_scale   <= i_cfg_data[15:0];
                CFG_KP:      r_kp      <= i_cfg_data[15:0];
                CFG_KD:      r_kd      <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_acc       <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // the done step loads or holds the output word itself
            if (o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_speed <= i_in.measured_speed;
                        r_state <= S_RAMP;
                    end
                end
                S_RAMP: begin
                    r_sp    <= n_sp;
                    r_state <= S_ERR;
                end
                S_ERR: begin
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    r_e     <= n_e;
                    r_state <= S_PROP;
                end
                S_PROP: begin
                    r_state <= S_DERIV;
                end
                S_DERIV: begin
                    r_sum   <= mul_p[SUM_W-1:0];
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc   <= n_acc;
                    r_clip  <= n_clip;
                    r_last  <= r_e;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_duty      <= n_duty;
                        r_rsp       <= n_rsp;
                        r_clamped   <= r_clip;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_out_valid;
    assign o_out.duty            = r_duty;
    assign o_out.ramped_setpoint = r_rsp;
    assign o_out.clamped         = r_clamped;
endmodule

### rtl/rpd_mul.sv
// ----------------------------------------------------------------------------
// rpd_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module rpd_mul (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [rpd_pkg::MUL_A_W-1:0]   i_a,
    input  logic signed [rpd_pkg::MUL_B_W-1:0]   i_b,
    output logic signed [rpd_pkg::MUL_P_W-1:0]   o_p
);
    import rpd_pkg::*;

    logic signed [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
        end
    end

    assign o_p = r_p;
endmodule
